@@ hdl/sra_pkg.sv @@
// ----------------------------------------------------------------------------
// sra_pkg
// shared types and constants of the sparse row accumulator
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int COLUMN_W     = 6;
    localparam int VALUE_W      = 16;
    localparam int OUT_SUM_W    = 48;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_PAD_W    = OUT_TDATA_W - COLUMN_W - OUT_SUM_W;

    localparam int NUM_COLS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF   = 48;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    localparam logic OP_TERM    = 1'b0;
    localparam logic OP_END_ROW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    typedef struct packed {
        logic                        last;
        logic                        has_entry;
        logic signed [OUT_SUM_W-1:0] sum;
        logic [COLUMN_W-1:0]         column;
    } t_out_word;

endpackage

@@ hdl/sra_sum_ram.sv @@
// ----------------------------------------------------------------------------
// sra_sum_ram
// column sum memory, one write and one registered read port
// ----------------------------------------------------------------------------
module sra_sum_ram
    import sra_pkg::*;
#(
    parameter int DEPTH = NUM_COLS_DEF,
    parameter int WIDTH = ACC_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/sra_term_unit.sv @@
// ----------------------------------------------------------------------------
// sra_term_unit
// product and saturating read-modify-write of one column sum
// ----------------------------------------------------------------------------
module sra_term_unit
    import sra_pkg::*;
#(
    parameter int NUM_COLS   = NUM_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF,
    localparam int COL_W = $clog2(NUM_COLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [COL_W-1:0]    i_col,
    input  logic [VALUE_W-1:0]  i_a_value,
    input  logic [VALUE_W-1:0]  i_b_value,
    input  logic [NUM_COLS-1:0] i_occupied,
    input  logic [ACC_BITS-1:0] i_rd_data,
    output logic                o_wr_en,
    output logic [COL_W-1:0]    o_wr_col,
    output logic [ACC_BITS-1:0] o_wr_data
);

    localparam int OP_W     = VALUE_W + 1;
    localparam int PROD_W   = 2 * OP_W;
    localparam int EXT_W    = (PROD_W > ACC_BITS) ? PROD_W : ACC_BITS;
    localparam int SIGN_BIT = (VALUE_BITS <= VALUE_W) ? VALUE_BITS - 1 : VALUE_W - 1;

    localparam logic signed [EXT_W-1:0] ACC_MAX_EXT =
        {{(EXT_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] ACC_MIN_EXT =
        {{(EXT_W - ACC_BITS + 1){1'b1}}, {(ACC_BITS - 1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

    function automatic logic signed [OP_W-1:0] to_operand(input logic [VALUE_W-1:0] raw);
        logic            sgn;
        logic [OP_W-1:0] res;
        sgn = (VALUE_BITS <= VALUE_W) ? raw[SIGN_BIT] : 1'b0;
        for (int i = 0; i < VALUE_W; i++) begin
            res[i] = (i < VALUE_BITS - 1) ? raw[i] : sgn;
        end
        res[OP_W-1] = sgn;
        return $signed(res);
    endfunction

    logic signed [OP_W-1:0]     w_op_a;
    logic signed [OP_W-1:0]     w_op_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic                       r_b_valid;
    logic [COL_W-1:0]           r_b_col;
    logic signed [PROD_W-1:0]   r_b_prod;
    logic                       r_fwd_valid;
    logic [COL_W-1:0]           r_fwd_col;
    logic [ACC_BITS-1:0]        r_fwd_sum;
    logic signed [EXT_W-1:0]    w_prod_ext;
    logic signed [ACC_BITS-1:0] w_prod_sat;
    logic signed [ACC_BITS-1:0] w_prev;
    logic signed [ACC_BITS:0]   w_sum;
    logic signed [ACC_BITS-1:0] w_sum_sat;
    logic [ACC_BITS-1:0]        w_wr_data;

    // multiply stage
    assign w_op_a = to_operand(i_a_value);
    assign w_op_b = to_operand(i_b_value);
    assign w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_b_valid   <= i_valid;
            r_fwd_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_col   <= i_col;
        r_b_prod  <= w_prod;
        r_fwd_col <= r_b_col;
        r_fwd_sum <= w_wr_data;
    end

    // accumulate stage
    assign w_prod_ext = EXT_W'(r_b_prod);

    always_comb begin
        priority if (w_prod_ext > ACC_MAX_EXT) begin
            w_prod_sat = ACC_MAX;
        end else if (w_prod_ext < ACC_MIN_EXT) begin
            w_prod_sat = ACC_MIN;
        end else begin
            w_prod_sat = ACC_BITS'(w_prod_ext);
        end
    end

    // write of the previous cycle is not yet in the read data
    assign w_prev = (r_fwd_valid && r_fwd_col == r_b_col) ? $signed(r_fwd_sum)
                                                          : $signed(i_rd_data);
    assign w_sum  = (ACC_BITS + 1)'(w_prev) + (ACC_BITS + 1)'(w_prod_sat);

    always_comb begin
        if (w_sum[ACC_BITS] != w_sum[ACC_BITS-1]) begin
            w_sum_sat = w_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum_sat = w_sum[ACC_BITS-1:0];
        end
    end

    assign w_wr_data = i_occupied[r_b_col] ? w_sum_sat : w_prod_sat;

    assign o_wr_en   = r_b_valid;
    assign o_wr_col  = r_b_col;
    assign o_wr_data = w_wr_data;

endmodule

@@ hdl/sra_out_queue.sv @@
// ----------------------------------------------------------------------------
// sra_out_queue
// small result queue between drain logic and output stream
// ----------------------------------------------------------------------------
module sra_out_queue
    import sra_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_out_word           i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output t_out_word           o_data,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_out_word           r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic [OQ_CNT_W-1:0] n_count;
    logic                w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ hdl/sparse_row_accumulator.sv @@
// ----------------------------------------------------------------------------
// sparse_row_accumulator
// dense row accumulator for a row-by-row sparse matrix product
// ----------------------------------------------------------------------------
// Product terms are taken one per cycle with no bubbles while no row
// is draining: the product is formed in the accept cycle and the
// column sum is read, updated with saturation and written back in the
// next, with a bypass for back-to-back terms on the same column. An
// end-of-row word holds the input until the drain has read every
// occupied column, in ascending order through the single read port of
// the sum memory (an empty row gives a single marker word). Read results
// go into a four-word queue, so the drain keeps its pace of one result
// per cycle while the output is taken and pauses while the queue has no
// room. Terms whose column is NUM_COLS or more are dropped.
module sparse_row_accumulator
    import sra_pkg::*;
#(
    parameter int NUM_COLS   = NUM_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // column, a_value, b_value
    input  logic                   s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_column, out_sum
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser    // has_entry
);

    localparam int COL_W = $clog2(NUM_COLS);

    t_state                r_state;
    t_state                n_state;
    logic [NUM_COLS-1:0]   r_occ;
    logic [NUM_COLS-1:0]   n_occ;
    logic [NUM_COLS-1:0]   w_rest;
    logic [COL_W-1:0]      w_first;
    logic                  w_any;
    logic                  w_in_acc;
    logic [COLUMN_W-1:0]   w_col_field;
    logic                  w_term_valid;
    logic                  w_eor;
    logic                  w_space;
    logic                  w_issue;
    logic                  w_rd_en;
    logic [COL_W-1:0]      w_rd_addr;
    logic [ACC_BITS-1:0]   w_rd_data;
    logic                  w_wr_en;
    logic [COL_W-1:0]      w_wr_col;
    logic [ACC_BITS-1:0]   w_wr_data;
    logic                  r_inf_valid;
    logic [COL_W-1:0]      r_inf_col;
    logic                  r_inf_has;
    logic                  r_inf_last;
    logic [OUT_SUM_W-1:0]  w_sum_out;
    t_out_word             w_push_data;
    t_out_word             w_head;
    logic                  w_pop;
    logic [OQ_CNT_W-1:0]   w_q_count;

    // input word
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_col_field   = s_axis_tdata[COLUMN_W-1:0];
    assign w_term_valid  = w_in_acc && (s_axis_tuser == OP_TERM)
                           && ({1'b0, w_col_field} < (COLUMN_W + 1)'(NUM_COLS));
    assign w_eor         = w_in_acc && (s_axis_tuser == OP_END_ROW);

    // lowest occupied column
    always_comb begin
        w_first = '0;
        for (int i = NUM_COLS - 1; i >= 0; i--) begin
            if (r_occ[i]) begin
                w_first = COL_W'(i);
            end
        end
    end

    assign w_any  = |r_occ;
    assign w_rest = r_occ & (r_occ - 1'b1);

    assign w_space = (w_q_count + {{(OQ_CNT_W - 1){1'b0}}, r_inf_valid}) < OQ_CNT_W'(OQ_DEPTH);
    assign w_issue = (r_state == ST_DRAIN) && w_space;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_eor) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_issue && (w_rest == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_occ = r_occ;
        if (w_wr_en) begin
            n_occ[w_wr_col] = 1'b1;
        end
        if (w_issue && w_any) begin
            n_occ[w_first] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_inf_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_inf_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inf_col  <= w_first;
        r_inf_has  <= w_any;
        r_inf_last <= (w_rest == '0);
    end

    // sum memory port sharing
    assign w_rd_en   = w_issue || w_term_valid;
    assign w_rd_addr = w_issue ? w_first : w_col_field[COL_W-1:0];

    sra_sum_ram #(
        .DEPTH (NUM_COLS),
        .WIDTH (ACC_BITS)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_col),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sra_term_unit #(
        .NUM_COLS   (NUM_COLS),
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_term_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_term_valid),
        .i_col      (w_col_field[COL_W-1:0]),
        .i_a_value  (s_axis_tdata[COLUMN_W +: VALUE_W]),
        .i_b_value  (s_axis_tdata[COLUMN_W + VALUE_W +: VALUE_W]),
        .i_occupied (r_occ),
        .i_rd_data  (w_rd_data),
        .o_wr_en    (w_wr_en),
        .o_wr_col   (w_wr_col),
        .o_wr_data  (w_wr_data)
    );

    // result word
    generate
        if (ACC_BITS >= OUT_SUM_W) begin : g_sum_trunc
            assign w_sum_out = w_rd_data[OUT_SUM_W-1:0];
        end else begin : g_sum_ext
            assign w_sum_out = {{(OUT_SUM_W - ACC_BITS){w_rd_data[ACC_BITS-1]}}, w_rd_data};
        end
    endgenerate

    assign w_push_data.last      = r_inf_last;
    assign w_push_data.has_entry = r_inf_has;
    assign w_push_data.sum       = r_inf_has ? w_sum_out : '0;
    assign w_push_data.column    = r_inf_has ? COLUMN_W'(r_inf_col) : '0;

    assign w_pop = m_axis_tvalid && m_axis_tready;

    sra_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_inf_valid),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .o_count (w_q_count)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_head.sum, w_head.column};
    assign m_axis_tlast = w_head.last;
    assign m_axis_tuser = w_head.has_entry;

`ifndef SYNTH
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_issue))
        else $error("term write overlaps drain read");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && (w_rest == '0)) |=> (r_state == ST_IDLE))
        else $error("drain did not end after last column");

    a_drain_clears_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_any) |=> ($countones(r_occ) == $countones($past(r_occ)) - 1))
        else $error("drain step did not clear exactly one column");

    a_marker_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("empty-row marker malformed");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inf_valid |-> (w_q_count < OQ_CNT_W'(OQ_DEPTH) || w_pop))
        else $error("result queue overflow");
`endif

endmodule

@@ tb/sparse_row_accumulator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_accumulator_tb
// self-checking bench for the sparse row accumulator
// ----------------------------------------------------------------------------
// Term and end-of-row words are streamed in through the slave port while a
// software copy of the column accumulators predicts every drained word. Each
// word on the master port is checked field by field against the oldest
// prediction. The run covers empty rows, factor extremes, zero products,
// ascending drain order over a full row, same-column bursts, large sums of
// both signs and random rows, with random bursts of idle cycles on both
// sides except in the large-sum test and the closing stretch.
module sparse_row_accumulator_tb;
    import sra_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam longint SUM_MAX = (longint'(1) << (OUT_SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        logic [COLUMN_W-1:0]         column;
        logic signed [OUT_SUM_W-1:0] sum;
        logic                        has_entry;
        logic                        last;
    } t_row_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // column, a_value, b_value
    logic                   s_axis_tuser = 1'b0; // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // out_column, out_sum
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;        // has_entry

    // predicted accumulator state
    logic signed [OUT_SUM_W-1:0] column_sum [NUM_COLS_DEF];
    bit                          column_used [NUM_COLS_DEF];
    t_row_result                 pending_results [$];

    bit idle_en = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int words_sent = 0;

    sparse_row_accumulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [OUT_SUM_W-1:0] clamp_sum(input longint v);
        if (v > SUM_MAX) return SUM_MAX[OUT_SUM_W-1:0];
        if (v < SUM_MIN) return SUM_MIN[OUT_SUM_W-1:0];
        return v[OUT_SUM_W-1:0];
    endfunction

    function automatic void accumulate_term(input logic [COLUMN_W-1:0] col,
                                            input logic signed [VALUE_W-1:0] a,
                                            input logic signed [VALUE_W-1:0] b);
        logic signed [OUT_SUM_W-1:0] product;
        product = clamp_sum(longint'(a) * longint'(b));
        if (column_used[col])
            column_sum[col] = clamp_sum(longint'(column_sum[col]) + longint'(product));
        else
            column_sum[col] = product;
        column_used[col] = 1'b1;
    endfunction

    function automatic void drain_row();
        int          final_col;
        t_row_result r;
        final_col = -1;
        for (int c = 0; c < NUM_COLS_DEF; c++)
            if (column_used[c]) final_col = c;
        if (final_col < 0) begin
            r.column = '0;
            r.sum = '0;
            r.has_entry = 1'b0;
            r.last = 1'b1;
            pending_results.push_back(r);
        end else begin
            for (int c = 0; c <= final_col; c++) begin
                if (column_used[c]) begin
                    r.column = c[COLUMN_W-1:0];
                    r.sum = column_sum[c];
                    r.has_entry = 1'b1;
                    r.last = (c == final_col);
                    pending_results.push_back(r);
                    column_used[c] = 1'b0;
                    column_sum[c] = '0;
                end
            end
        end
    endfunction

    // the word is predicted when presented; nothing can overtake it
    task automatic send_word(input logic op, input logic [COLUMN_W-1:0] col,
                             input logic signed [VALUE_W-1:0] a,
                             input logic signed [VALUE_W-1:0] b);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - COLUMN_W - 2 * VALUE_W){1'b0}}, b, a, col};
        if (op == OP_TERM)
            accumulate_term(col, a, b);
        else
            drain_row();
        words_sent++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_term(input int col, input logic signed [VALUE_W-1:0] a,
                             input logic signed [VALUE_W-1:0] b);
        send_word(OP_TERM, col[COLUMN_W-1:0], a, b);
    endtask

    task automatic end_row();
        send_word(OP_END_ROW, COLUMN_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom));
    endtask

    // called right after an acceptance, so valid gets one update in that step
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic test_empty_row();
        end_row();
        end_row();
        send_term(0, 16'sd3, 16'sd4);
        end_row();
        end_row();
    endtask

    task automatic test_factor_extremes();
        send_term(0, 16'sh8000, 16'sh8000);
        send_term(63, 16'sh7fff, 16'sh7fff);
        send_term(31, 16'sh8000, 16'sh7fff);
        send_term(17, 16'sh0000, 16'sh7fff);
        send_term(42, 16'shffff, 16'sh0001);
        send_term(42, 16'sh0001, 16'sh0001);
        send_term(8, 16'sh7fff, 16'sh8000);
        send_term(8, 16'sh8000, 16'sh7fff);
        end_row();
    endtask

    task automatic test_full_row_order();
        for (int c = NUM_COLS_DEF - 1; c >= 0; c--)
            send_term(c, pick_value(), pick_value());
        end_row();
    endtask

    task automatic test_same_column_burst();
        for (int i = 0; i < 6; i++)
            send_term(9, pick_value(), pick_value());
        send_term(10, 16'sd100, -16'sd7);
        send_term(9, 16'sd5, 16'sd5);
        send_term(10, -16'sd100, -16'sd7);
        end_row();
    endtask

    // repeated extreme products build large sums of both signs
    task automatic test_large_sums();
        idle_en = 1'b0;
        for (int i = 0; i < 8; i++) begin
            send_term(5, 16'sh8000, 16'sh8000);
            send_term(6, 16'sh8000, 16'sh7fff);
        end
        send_term(5, 16'sh7fff, -16'sd1);
        send_term(6, 16'sh7fff, 16'sd1);
        send_term(5, 16'sh8000, 16'sh8000);
        end_row();
        for (int i = 0; i < 8; i++)
            send_term(60, 16'sh8000, 16'sh7fff);
        send_term(60, 16'sh7fff, 16'sh7fff);
        end_row();
        idle_en = 1'b1;
    endtask

    task automatic random_rows(input int word_budget, input bit allow_idle);
        int start_count;
        int terms;
        int base_col;
        int row_index;
        start_count = words_sent;
        row_index = 0;
        while (words_sent - start_count < word_budget) begin
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            terms = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            base_col = $urandom_range(0, NUM_COLS_DEF - 4);
            for (int i = 0; i < terms; i++) begin
                if ($urandom_range(0, 1) == 0)
                    send_term(base_col + $urandom_range(0, 3), pick_value(), pick_value());
                else
                    send_term($urandom_range(0, NUM_COLS_DEF - 1), pick_value(), pick_value());
            end
            end_row();
            if (allow_idle && (row_index == 3 || $urandom_range(0, 7) == 0))
                wait_results_drained();
            row_index++;
        end
        idle_en = allow_idle;
    endtask

    // receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: out_column %0d out_sum %0d",
                       m_axis_tdata[COLUMN_W-1:0],
                       $signed(m_axis_tdata[COLUMN_W +: OUT_SUM_W]));
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[COLUMN_W-1:0] !== want.column) begin
                    $error("out_column mismatch: expected %0d, actual %0d",
                           want.column, m_axis_tdata[COLUMN_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[COLUMN_W +: OUT_SUM_W] !== want.sum) begin
                    $error("out_sum mismatch: expected %0d, actual %0d",
                           want.sum, $signed(m_axis_tdata[COLUMN_W +: OUT_SUM_W]));
                    fail_count++;
                end
                if (m_axis_tuser !== want.has_entry) begin
                    $error("has_entry mismatch: expected %0b, actual %0b",
                           want.has_entry, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b",
                           want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** sparse_row_accumulator: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        for (int c = 0; c < NUM_COLS_DEF; c++) begin
            column_sum[c] = '0;
            column_used[c] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_row();
        test_factor_extremes();
        test_full_row_order();
        test_same_column_burst();
        test_large_sums();
        random_rows(100, 1'b1);
        random_rows(30, 1'b0);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** sparse_row_accumulator: PASSED **");
        else
            $display("** sparse_row_accumulator: FAILED **");
        $finish;
    end

endmodule

@@ sparse_row_accumulator.f @@
hdl/sra_pkg.sv
hdl/sra_sum_ram.sv
hdl/sra_term_unit.sv
hdl/sra_out_queue.sv
hdl/sparse_row_accumulator.sv
tb/sparse_row_accumulator_tb.sv
